>>> hw/rtl/button_press_classifier_assert.svh
// assertion macros for the button press classifier
// each expects clk and arst_n in the scope where it is used
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

`define BPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BPC_ASSERT_SAME(lbl, ante, cons, msg)

`define BPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bpc_pkg.sv
package bpc_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_WAIT_TIMEOUT     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;

	localparam logic [15:0] WAIT_TIMEOUT_RST     = 16'd5000;
	localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd50;
	localparam logic [11:0] LONG_PRESS_TICKS_RST = 12'd500;

	localparam logic [1:0] PT_NONE  = 2'd0;
	localparam logic [1:0] PT_SHORT = 2'd1;
	localparam logic [1:0] PT_LONG  = 2'd2;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_WAIT        = 3'd1,
		PH_DEB_PRESS   = 3'd2,
		PH_HOLD        = 3'd3,
		PH_DEB_RELEASE = 3'd4
	} phase_t;

	typedef struct packed {
		logic [15:0] wait_timeout;
		logic [7:0]  debounce_ticks;
		logic [11:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] press_type;
	} result_t;

endpackage

>>> hw/rtl/bpc_core.sv
`include "button_press_classifier_assert.svh"

module bpc_core #(
	parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           kind,
	input  logic           pin_level,
	input  bpc_pkg::cfg_t  cfg,
	output bpc_pkg::result_t res
);

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	bpc_pkg::phase_t phase_q, phase_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic long_q, long_d;

	logic reach_wait_inc, reach_deb_cur, reach_deb_inc, reach_long_cur;
	logic is_start;
	logic [1:0] hold_type;

	function automatic logic reached(input logic [COUNT_BITS-1:0] c, input logic [15:0] thr);
		reached = (CMP_W'(c) >= CMP_W'(thr)) || (c == {COUNT_BITS{1'b1}});
	endfunction

	// saturating increment
	assign cnt_inc = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + COUNT_BITS'(1);

	assign reach_wait_inc = reached(cnt_inc, cfg.wait_timeout);
	assign reach_deb_cur  = reached(cnt_q, {8'd0, cfg.debounce_ticks});
	assign reach_deb_inc  = reached(cnt_inc, {8'd0, cfg.debounce_ticks});
	assign reach_long_cur = reached(cnt_q, {4'd0, cfg.long_press_ticks});

	assign is_start  = (kind == bpc_pkg::KIND_START);
	assign hold_type = long_q ? bpc_pkg::PT_LONG : bpc_pkg::PT_SHORT;

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		long_d  = long_q;
		if (is_start) begin
			if (phase_q == bpc_pkg::PH_IDLE) begin
				phase_d = bpc_pkg::PH_WAIT;
				cnt_d   = '0;
				long_d  = 1'b0;
			end
		end else begin
			case (phase_q)
				bpc_pkg::PH_IDLE: begin
				end
				bpc_pkg::PH_WAIT: begin
					if (pin_level) begin
						cnt_d = cnt_inc;
						if (reach_wait_inc) begin
							phase_d = bpc_pkg::PH_IDLE;
							cnt_d   = '0;
							long_d  = 1'b0;
						end
					end else begin
						phase_d = bpc_pkg::PH_DEB_PRESS;
						cnt_d   = '0;
					end
				end
				bpc_pkg::PH_DEB_PRESS: begin
					if (!reach_deb_cur) begin
						cnt_d = cnt_inc;
					end else if (pin_level) begin
						// glitch
						phase_d = bpc_pkg::PH_IDLE;
						cnt_d   = '0;
						long_d  = 1'b0;
					end else begin
						phase_d = bpc_pkg::PH_HOLD;
						cnt_d   = '0;
						long_d  = 1'b0;
					end
				end
				bpc_pkg::PH_HOLD: begin
					if (!pin_level) begin
						if (reach_long_cur) long_d = 1'b1;
						else cnt_d = cnt_inc;
					end else if (cfg.debounce_ticks == 8'd0) begin
						phase_d = bpc_pkg::PH_IDLE;
						cnt_d   = '0;
						long_d  = 1'b0;
					end else begin
						phase_d = bpc_pkg::PH_DEB_RELEASE;
						cnt_d   = '0;
					end
				end
				bpc_pkg::PH_DEB_RELEASE: begin
					cnt_d = cnt_inc;
					if (reach_deb_inc) begin
						phase_d = bpc_pkg::PH_IDLE;
						cnt_d   = '0;
						long_d  = 1'b0;
					end
				end
				default: begin
					phase_d = bpc_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// result of the beat in hand
	always_comb begin
		res.valid      = 1'b0;
		res.press_type = bpc_pkg::PT_NONE;
		if (fire && !is_start) begin
			case (phase_q)
				bpc_pkg::PH_WAIT: begin
					res.valid = pin_level && reach_wait_inc;
				end
				bpc_pkg::PH_DEB_PRESS: begin
					res.valid = reach_deb_cur && pin_level;
				end
				bpc_pkg::PH_HOLD: begin
					res.valid      = pin_level && (cfg.debounce_ticks == 8'd0);
					res.press_type = hold_type;
				end
				bpc_pkg::PH_DEB_RELEASE: begin
					res.valid      = reach_deb_inc;
					res.press_type = hold_type;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpc_pkg::PH_IDLE;
			cnt_q   <= '0;
			long_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			long_q  <= long_d;
		end
	end

	`BPC_ASSERT_SAME(a_res_not_idle, res.valid, phase_q != bpc_pkg::PH_IDLE, "result from idle")
	`BPC_ASSERT_NEXT(a_finish_clears, res.valid, (phase_q == bpc_pkg::PH_IDLE) && (cnt_q == '0) && !long_q, "state not cleared after result")
	`BPC_ASSERT_SAME(a_long_phase, long_q, (phase_q == bpc_pkg::PH_HOLD) || (phase_q == bpc_pkg::PH_DEB_RELEASE), "long flag outside hold")

endmodule

>>> hw/rtl/button_press_classifier.sv
// one beat accepted per cycle, no bubbles while the output is taken
// an accepted beat is registered in the stage, processed by the core when it fires,
// and any result is registered into out_valid and press_type
// the state update of the single stage sets the rate of one beat per cycle if not stalled
// reset: asynchronous, active low; classifier idle, registers at 5000/50/500

module button_press_classifier #(
	parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic                                pin_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          press_type,
	input  logic                                cfg_wr_en,
	input  logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	bpc_pkg::cfg_t    cfg_q;
	bpc_pkg::result_t res;

	logic valid_s1, kind_s1, pin_s1;
	logic out_valid_q;
	logic [1:0] press_type_q;
	logic blocked, fire, accept;

	// the stage beat waits while a result still sits unread
	assign blocked  = out_valid_q && out_stall;
	assign fire     = valid_s1 && !blocked;
	assign in_stall = valid_s1 && blocked;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_timeout     <= bpc_pkg::WAIT_TIMEOUT_RST;
			cfg_q.debounce_ticks   <= bpc_pkg::DEBOUNCE_TICKS_RST;
			cfg_q.long_press_ticks <= bpc_pkg::LONG_PRESS_TICKS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bpc_pkg::REG_WAIT_TIMEOUT:     cfg_q.wait_timeout     <= cfg_data;
				bpc_pkg::REG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= cfg_data[7:0];
				bpc_pkg::REG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			pin_s1  <= pin_level;
		end
	end

	bpc_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.kind      (kind_s1),
		.pin_level (pin_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			press_type_q <= res.press_type;
		end
	end

	assign out_valid  = out_valid_q;
	assign press_type = press_type_q;

endmodule
